/* design/scba_pkg.sv */
// Shared types, constants and class tables of the size-class block allocator.
package scba_pkg;

  localparam int unsigned NumChunks     = 16;
  localparam int unsigned ChunkBytes    = 16384;
  localparam int unsigned NumClasses    = 16;
  localparam int unsigned GranuleShift  = 4;
  localparam int unsigned ChunkGranules = ChunkBytes >> GranuleShift;
  localparam int unsigned LinkDepth     = NumChunks * ChunkGranules;
  localparam int unsigned IdxW          = $clog2(LinkDepth);
  localparam int unsigned HeadW         = IdxW + 1;
  localparam int unsigned LeftW         = $clog2(ChunkGranules) + 1;
  localparam int unsigned ChunkCntW     = $clog2(NumChunks + 1);
  localparam int unsigned ClsW          = $clog2(NumClasses);
  localparam int unsigned LiveW         = 15;
  localparam int unsigned SizeW         = 12;
  localparam int unsigned AddrW         = 18;
  localparam int unsigned MaxClassBytes = 704;
  localparam logic [LiveW-1:0] LiveMax  = '1;

  localparam int unsigned ClassBytes [NumClasses] = '{
    16, 32, 64, 96, 128, 160, 192, 224, 256, 320, 384, 416, 448, 512, 640, 704
  };

  // Blocks per chunk for each class.
  localparam int unsigned ClassCap [NumClasses] = '{
    ChunkBytes / 16,  ChunkBytes / 32,  ChunkBytes / 64,  ChunkBytes / 96,
    ChunkBytes / 128, ChunkBytes / 160, ChunkBytes / 192, ChunkBytes / 224,
    ChunkBytes / 256, ChunkBytes / 320, ChunkBytes / 384, ChunkBytes / 416,
    ChunkBytes / 448, ChunkBytes / 512, ChunkBytes / 640, ChunkBytes / 704
  };

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ZERO    = 2'd1,
    ST_OVER    = 2'd2,
    ST_EXHAUST = 2'd3
  } status_e;

  typedef struct packed {
    action_e         action;
    status_e         status;
    logic [ClsW-1:0] cls;
    logic [IdxW-1:0] idx;
  } req_t;

  localparam int unsigned ReqW = $bits(req_t);

endpackage

/* design/scba_front.sv */
// Front end: decodes a request and maps its size to a block class.
module scba_front (
  input  logic [31:0]   s_axis_tdata,  // action[1:0], size[13:2], addr[31:14]
  output scba_pkg::req_t req_o
);
  import scba_pkg::*;

  logic [1:0]       action;
  logic [SizeW-1:0] size;
  logic [AddrW-1:0] addr;
  logic [ClsW-1:0]  cls;
  logic             found;

  assign action = s_axis_tdata[1:0];
  assign size   = s_axis_tdata[13:2];
  assign addr   = s_axis_tdata[31:14];

  always_comb begin
    cls   = ClsW'(NumClasses - 1);
    found = 1'b0;
    for (int c = 0; c < NumClasses - 1; c++) begin
      if (!found && (size <= SizeW'(ClassBytes[c]))) begin
        cls   = ClsW'(c);
        found = 1'b1;
      end
    end
  end

  always_comb begin
    req_o.action = action_e'(action);
    req_o.cls    = cls;
    req_o.idx    = addr[AddrW-1:GranuleShift];
    if ((action_e'(action) == ACT_ALLOC) || (action_e'(action) == ACT_FREE)) begin
      if (size == '0) begin
        req_o.status = ST_ZERO;
      end else if (size > SizeW'(MaxClassBytes)) begin
        req_o.status = ST_OVER;
      end else begin
        req_o.status = ST_OK;
      end
    end else begin
      req_o.status = ST_OK;
    end
  end

endmodule

/* design/scba_queue.sv */
// Two-entry request queue between the front end and the back end.
module scba_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  scba_pkg::req_t data_i,
  output logic           full_o,
  output logic           empty_o,
  input  logic           pop_i,
  output scba_pkg::req_t data_o
);
  import scba_pkg::*;

  req_t       mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

/* design/scba_back.sv */
// Back end: free lists, carving state, link memory and the result register.
module scba_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     empty_i,
  input  scba_pkg::req_t           req_i,
  output logic                     pop_o,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [39:0]              m_axis_tdata
);
  import scba_pkg::*;

  typedef enum logic {S_IDLE, S_POP} state_e;

  state_e                 state_q;
  logic [HeadW-1:0]       head_q  [NumClasses];
  logic [IdxW-1:0]        next_q  [NumClasses];
  logic [LeftW-1:0]       left_q  [NumClasses];
  logic [ChunkCntW-1:0]   chunks_q;
  logic [LiveW-1:0]       live_q;
  logic [ClsW-1:0]        cls_q;
  logic [IdxW-1:0]        idx_q;
  logic                   ovalid_q;
  logic [AddrW-1:0]       oaddr_q;
  status_e                ostat_q;

  logic [HeadW-1:0]       link_mem [LinkDepth];
  logic [HeadW-1:0]       rd_data_q;
  logic                   link_we;
  logic                   link_re;
  logic [IdxW-1:0]        link_addr;

  logic                   out_free;
  logic [ClsW-1:0]        c;
  logic [IdxW-1:0]        step;
  logic [IdxW-1:0]        chunk_base;
  logic [LiveW-1:0]       live_inc;
  logic [LiveW-1:0]       live_dec;

  assign out_free   = !ovalid_q || m_axis_tready;
  assign c          = req_i.cls;
  assign pop_o      = (state_q == S_IDLE) && !empty_i && out_free;
  assign step       = IdxW'(ClassBytes[c] >> GranuleShift);
  assign chunk_base = IdxW'(chunks_q) * IdxW'(ChunkGranules);
  assign live_inc   = (live_q < LiveMax) ? live_q + 1'b1 : live_q;
  assign live_dec   = (live_q != '0) ? live_q - 1'b1 : live_q;

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {chunks_q, live_q, ostat_q, oaddr_q};

  always_comb begin
    link_we   = 1'b0;
    link_re   = 1'b0;
    link_addr = req_i.idx;
    if (pop_o && (req_i.status == ST_OK)) begin
      if ((req_i.action == ACT_ALLOC) && (head_q[c] != '0)) begin
        link_re   = 1'b1;
        link_addr = IdxW'(head_q[c] - 1'b1);
      end else if (req_i.action == ACT_FREE) begin
        link_we = 1'b1;
      end
    end
  end

  // Link memory: written on free, read on pop.
  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_addr] <= head_q[c];
    end
    if (link_re) begin
      rd_data_q <= link_mem[link_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
      oaddr_q  <= '0;
      ostat_q  <= ST_OK;
      cls_q    <= '0;
      idx_q    <= '0;
      chunks_q <= '0;
      live_q   <= '0;
      for (int k = 0; k < NumClasses; k++) begin
        head_q[k] <= '0;
        next_q[k] <= '0;
        left_q[k] <= '0;
      end
    end else begin
      if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (pop_o) begin
            ovalid_q <= 1'b1;
            oaddr_q  <= '0;
            ostat_q  <= req_i.status;
            cls_q    <= c;
            case (req_i.action)
              ACT_ALLOC: begin
                if (req_i.status == ST_OK) begin
                  if (head_q[c] != '0) begin
                    // Finish the pop once the link word is back.
                    ovalid_q <= 1'b0;
                    idx_q    <= IdxW'(head_q[c] - 1'b1);
                    state_q  <= S_POP;
                  end else if (left_q[c] != '0) begin
                    oaddr_q   <= {next_q[c], GranuleShift'(0)};
                    next_q[c] <= next_q[c] + step;
                    left_q[c] <= left_q[c] - 1'b1;
                    live_q    <= live_inc;
                  end else if (chunks_q < ChunkCntW'(NumChunks)) begin
                    oaddr_q   <= {chunk_base, GranuleShift'(0)};
                    next_q[c] <= chunk_base + step;
                    left_q[c] <= LeftW'(ClassCap[c] - 1);
                    chunks_q  <= chunks_q + 1'b1;
                    live_q    <= live_inc;
                  end else begin
                    ostat_q <= ST_EXHAUST;
                  end
                end
              end
              ACT_FREE: begin
                if (req_i.status == ST_OK) begin
                  head_q[c] <= {1'b0, req_i.idx} + 1'b1;
                  live_q    <= live_dec;
                end
              end
              ACT_CLEAR: begin
                chunks_q <= '0;
                live_q   <= '0;
                for (int k = 0; k < NumClasses; k++) begin
                  head_q[k] <= '0;
                  next_q[k] <= '0;
                  left_q[k] <= '0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_POP: begin
          if (out_free) begin
            ovalid_q      <= 1'b1;
            oaddr_q       <= {idx_q, GranuleShift'(0)};
            ostat_q       <= ST_OK;
            head_q[cls_q] <= rd_data_q;
            live_q        <= live_inc;
            state_q       <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* design/size_class_block_allocator_unit.sv */
// Results are registered; a free-list pop waits on the registered link RAM read.
// Throughput: one request per cycle for carve, free and error cases while the
// output is free; a free-list pop holds the next request until S_POP is done.
// A two-entry queue lets requests enter while a result waits on the output.
// Reset (async, active low) empties all free lists and carving state and clears
// both counters; link RAM content is left as is and needs no clearing pass.
module size_class_block_allocator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // action[1:0], size[13:2], addr[31:14]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // addr_res[17:0], status[19:18],
                                      // live_blocks[34:20], chunks_used[39:35]
);
  import scba_pkg::*;

  req_t front_req;
  req_t queue_req;
  logic q_full, q_empty, q_pop, q_push;

  assign s_axis_tready = !q_full;
  assign q_push        = s_axis_tvalid && !q_full;

  scba_front u_front (
    .s_axis_tdata(s_axis_tdata),
    .req_o       (front_req)
  );

  scba_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (front_req),
    .full_o (q_full),
    .empty_o(q_empty),
    .pop_i  (q_pop),
    .data_o (queue_req)
  );

  scba_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (q_empty),
    .req_i        (queue_req),
    .pop_o        (q_pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

endmodule
